// ----- hw/rtl/odo_pkg.sv -----
// Shared types, constants and tables for the differential-drive odometry block.
// Used by odo_ctrl, odo_dp and differential_drive_odometry_top; no dependencies.
package odo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 6;

    localparam logic [33:0] GAIN_Q30   = 34'd652032874;
    localparam logic [31:0] HEAD_SCALE = 32'd2935890503;
    // ceil(2^67 / 5^9) split at bit 24: (P << 23) / 10^9 == (P * RECIP) >> 53
    // for any product P below 2^32
    localparam logic [23:0] RECIP_LO   = 24'd10525531;
    localparam logic [22:0] RECIP_HI   = 23'd4503599;
    localparam logic [23:0] IWB_RESET  = 24'd65536;
    localparam logic [31:0] QUARTER    = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN  = 32'h8000_0000;

    typedef enum logic [3:0] {
        MO_NONE,
        MO_SDT,
        MO_DDT,
        MO_R,
        MO_RATE,
        MO_LO,
        MO_HI,
        MO_DL,
        MO_DH,
        MO_X,
        MO_Y
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    cordic_start;
        logic    cordic_half;
        logic    lat_p;
        mul_op_t mul_op;
        logic    lat_r;
        logic    lat_rate;
        logic    lat_lohi;
        logic    lat_dl;
        logic    lat_dist;
        logic    yaw_upd;
        logic    pos_x_upd;
        logic    pos_y_upd;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cordic_busy;
    } dp_stat_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/odo_ctrl.sv -----
// Sequencer for the odometry update: steps the shared multiplier, waits on the
// CORDIC unit, and owns the result valid flag. Depends on odo_pkg.
module odo_ctrl import odo_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MSDT,
        ST_MDDT,
        ST_MR,
        ST_MRATE,
        ST_MLO,
        ST_MHI,
        ST_INC,
        ST_MDH,
        ST_DIST,
        ST_WAITDC,
        ST_MX,
        ST_MY,
        ST_PY,
        ST_WAITC2,
        ST_FIN
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.mul_op = MO_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load         = in_valid;
                cmd.cordic_start = in_valid;
            end
            ST_MSDT:  cmd.mul_op = MO_SDT;
            ST_MDDT:
            begin
                cmd.mul_op = MO_DDT;
                cmd.lat_p  = 1'b1;
            end
            ST_MR:    cmd.mul_op = MO_R;
            ST_MRATE:
            begin
                cmd.mul_op = MO_RATE;
                cmd.lat_r  = 1'b1;
            end
            ST_MLO:
            begin
                cmd.mul_op   = MO_LO;
                cmd.lat_rate = 1'b1;
            end
            ST_MHI:
            begin
                cmd.mul_op   = MO_HI;
                cmd.lat_lohi = 1'b1;
            end
            ST_INC:
            begin
                cmd.yaw_upd = 1'b1;
                cmd.mul_op  = MO_DL;
            end
            ST_MDH:
            begin
                cmd.mul_op = MO_DH;
                cmd.lat_dl = 1'b1;
            end
            ST_DIST:  cmd.lat_dist = 1'b1;
            ST_MX:    cmd.mul_op = MO_X;
            ST_MY:
            begin
                cmd.mul_op    = MO_Y;
                cmd.pos_x_upd = 1'b1;
            end
            ST_PY:
            begin
                cmd.pos_y_upd    = 1'b1;
                cmd.cordic_start = 1'b1;
                cmd.cordic_half  = 1'b1;
            end
            ST_FIN:   cmd.out_load = !out_valid_reg || out_ready;
            default:  cmd.mul_op = MO_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_FIN && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_MSDT;
                    end
                end
                ST_MSDT:  state_reg <= ST_MDDT;
                ST_MDDT:  state_reg <= ST_MR;
                ST_MR:    state_reg <= ST_MRATE;
                ST_MRATE: state_reg <= ST_MLO;
                ST_MLO:   state_reg <= ST_MHI;
                ST_MHI:   state_reg <= ST_INC;
                ST_INC:   state_reg <= ST_MDH;
                ST_MDH:   state_reg <= ST_DIST;
                ST_DIST:  state_reg <= ST_WAITDC;
                ST_WAITDC:
                begin
                    if (!stat.cordic_busy)
                    begin
                        state_reg <= ST_MX;
                    end
                end
                ST_MX:    state_reg <= ST_MY;
                ST_MY:    state_reg <= ST_PY;
                ST_PY:    state_reg <= ST_WAITC2;
                ST_WAITC2:
                begin
                    if (!stat.cordic_busy)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/odo_dp.sv -----
// Odometry datapath: pose state, shared 34x34 multiplier, reciprocal-multiply
// divide by 10^9, iterative CORDIC and the result register. Depends on odo_pkg.
module odo_dp import odo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output dp_stat_t           stat,
    input  logic               cfg_wr_en,
    input  logic [23:0]        cfg_wr_data,
    input  logic signed [15:0] left_velocity,
    input  logic signed [15:0] right_velocity,
    input  logic [15:0]        elapsed_time,
    output logic signed [47:0] pos_x,
    output logic signed [47:0] pos_y,
    output logic [31:0]        heading,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w,
    output logic signed [15:0] linear_velocity,
    output logic signed [31:0] angular_rate
);

    logic [23:0]        ivw_reg;
    logic signed [47:0] px_reg, py_reg;
    logic [31:0]        yaw_reg;

    logic signed [15:0] vl_reg, vr_reg;
    logic [15:0]        dt_reg;
    logic signed [16:0] sum, diff;
    logic [16:0]        smag, dmag;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_reg;
    logic [56:0]        r_reg;
    logic [31:0]        lohi_reg;
    logic signed [31:0] rate_reg;
    logic [57:0]        mid;
    logic [31:0]        inc;

    logic [31:0]        p_reg;
    logic [31:0]        dl_reg;
    logic [55:0]        quo_sum;
    logic signed [27:0] travel_reg;

    logic               cordic_busy_reg;
    logic [STEP_W-1:0]  ccnt_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic               cflip_reg;
    logic [31:0]        c_ang, c_ang2;
    logic               c_flip;
    logic signed [33:0] c_sx, c_sy;
    logic [32:0]        c_atan;
    logic signed [33:0] cos_v, sin_v;

    logic signed [37:0] pstep;
    logic signed [49:0] px_sum, py_sum;
    logic signed [47:0] px_sat, py_sat;
    logic signed [15:0] qz_v, qw_v;

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        if (v[49:47] == 3'b000 || v[49:47] == 3'b111)
        begin
            return v[47:0];
        end
        return v[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    endfunction

    function automatic logic signed [15:0] q15(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [19:0] r;
        t = {v[33], v} + 35'sd16384;
        r = t[34:15];
        if (r > 20'sd32767)
        begin
            return 16'sd32767;
        end
        if (r < -20'sd32768)
        begin
            return -16'sd32768;
        end
        return r[15:0];
    endfunction

    assign sum  = {vl_reg[15], vl_reg} + {vr_reg[15], vr_reg};
    assign diff = {vr_reg[15], vr_reg} - {vl_reg[15], vl_reg};
    assign smag = sum[16]  ? 17'(-sum)  : 17'(sum);
    assign dmag = diff[16] ? 17'(-diff) : 17'(diff);

    assign cos_v = cflip_reg ? -cx_reg : cx_reg;
    assign sin_v = cflip_reg ? -cy_reg : cy_reg;

    // Shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_op)
            MO_SDT:
            begin
                mul_a = {17'd0, smag};
                mul_b = {18'd0, dt_reg};
            end
            MO_DDT:
            begin
                mul_a = {17'd0, dmag};
                mul_b = {18'd0, dt_reg};
            end
            MO_R:
            begin
                mul_a = mul_reg[33:0];
                mul_b = {10'd0, ivw_reg};
            end
            MO_RATE:
            begin
                mul_a = {17'd0, dmag};
                mul_b = {10'd0, ivw_reg};
            end
            MO_LO:
            begin
                mul_a = {2'd0, r_reg[31:0]};
                mul_b = {2'd0, HEAD_SCALE};
            end
            MO_HI:
            begin
                mul_a = {9'd0, r_reg[56:32]};
                mul_b = {2'd0, HEAD_SCALE};
            end
            MO_DL:
            begin
                mul_a = {2'd0, p_reg};
                mul_b = {10'd0, RECIP_LO};
            end
            MO_DH:
            begin
                mul_a = {2'd0, p_reg};
                mul_b = {11'd0, RECIP_HI};
            end
            MO_X:
            begin
                mul_a = {{6{travel_reg[27]}}, travel_reg};
                mul_b = cos_v;
            end
            MO_Y:
            begin
                mul_a = {{6{travel_reg[27]}}, travel_reg};
                mul_b = sin_v;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mid = mul_reg[57:0] + {26'd0, lohi_reg};
    assign inc = diff[16] ? 32'(-mid[47:16]) : mid[47:16];

    // High partial product plus the carried-down low partial, quotient from bit 29 up
    assign quo_sum = mul_reg[55:0] + {24'd0, dl_reg};

    assign pstep  = mul_reg[67:30];
    assign px_sum = {{2{px_reg[47]}}, px_reg} + {{12{pstep[37]}}, pstep};
    assign py_sum = {{2{py_reg[47]}}, py_reg} + {{12{pstep[37]}}, pstep};
    assign px_sat = sat48(px_sum);
    assign py_sat = sat48(py_sum);

    assign c_ang  = cmd.cordic_half ? {yaw_reg[31], yaw_reg[31:1]} : yaw_reg;
    assign c_flip = c_ang[31] ^ c_ang[30];
    assign c_ang2 = c_flip ? (c_ang ^ HALF_TURN) : c_ang;
    assign c_sx   = cx_reg >>> ccnt_reg[4:0];
    assign c_sy   = cy_reg >>> ccnt_reg[4:0];
    assign c_atan = {1'b0, atan_lut(ccnt_reg[4:0])};

    assign qz_v = q15(sin_v);
    assign qw_v = q15(cos_v);

    assign stat.cordic_busy = cordic_busy_reg;

    // Control and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivw_reg         <= IWB_RESET;
            px_reg          <= '0;
            py_reg          <= '0;
            yaw_reg         <= '0;
            cordic_busy_reg <= 1'b0;
            ccnt_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ivw_reg <= cfg_wr_data;
            end
            if (cmd.yaw_upd)
            begin
                yaw_reg <= yaw_reg + inc;
            end
            if (cmd.pos_x_upd)
            begin
                px_reg <= px_sat;
            end
            if (cmd.pos_y_upd)
            begin
                py_reg <= py_sat;
            end

            if (cmd.cordic_start)
            begin
                cordic_busy_reg <= 1'b1;
                ccnt_reg        <= '0;
            end
            else if (cordic_busy_reg)
            begin
                ccnt_reg <= ccnt_reg + STEP_W'(1);
                if (ccnt_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    cordic_busy_reg <= 1'b0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        if (cmd.load)
        begin
            vl_reg <= left_velocity;
            vr_reg <= right_velocity;
            dt_reg <= elapsed_time;
        end
        if (cmd.lat_p)
        begin
            p_reg <= mul_reg[31:0];
        end
        if (cmd.lat_r)
        begin
            r_reg <= mul_reg[56:0];
        end
        if (cmd.lat_rate)
        begin
            rate_reg <= diff[16] ? -$signed({7'd0, mul_reg[40:16]})
                                 : $signed({7'd0, mul_reg[40:16]});
        end
        if (cmd.lat_lohi)
        begin
            lohi_reg <= mul_reg[63:32];
        end
        if (cmd.lat_dl)
        begin
            dl_reg <= mul_reg[55:24];
        end
        if (cmd.lat_dist)
        begin
            travel_reg <= sum[16] ? -$signed({1'b0, quo_sum[55:29]})
                                  : $signed({1'b0, quo_sum[55:29]});
        end
        if (cmd.cordic_start)
        begin
            cx_reg    <= GAIN_Q30;
            cy_reg    <= '0;
            cz_reg    <= {c_ang2[31], c_ang2};
            cflip_reg <= c_flip;
        end
        else if (cordic_busy_reg)
        begin
            if (!cz_reg[32])
            begin
                cx_reg <= cx_reg - c_sy;
                cy_reg <= cy_reg + c_sx;
                cz_reg <= cz_reg - $signed(c_atan);
            end
            else
            begin
                cx_reg <= cx_reg + c_sy;
                cy_reg <= cy_reg - c_sx;
                cz_reg <= cz_reg + $signed(c_atan);
            end
        end
        if (cmd.out_load)
        begin
            pos_x           <= px_reg;
            pos_y           <= py_reg;
            heading         <= yaw_reg;
            quat_z          <= qz_v;
            quat_w          <= qw_v;
            linear_velocity <= sum[16:1];
            angular_rate    <= rate_reg;
        end
    end

    a_cordic_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cordic_start |-> !cordic_busy_reg)
        else $error("cordic restarted while busy");

    a_cordic_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_busy_reg |-> ccnt_reg < STEP_W'(CORDIC_STEPS))
        else $error("cordic step count out of range");

    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lat_dist |-> !quo_sum[55])
        else $error("travel quotient out of range");

    a_out_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !cordic_busy_reg)
        else $error("result loaded while a unit is busy");

endmodule

// ----- hw/rtl/differential_drive_odometry_top.sv -----
// Top level of the differential-drive odometry block: stream ports, config
// write port, sequencer and datapath. Depends on odo_pkg, odo_ctrl, odo_dp.
//
// Usage:
//   Slave stream carries one beat per update: wheel speeds in mm/s and the
//   elapsed time in microseconds. Each accepted beat yields exactly one
//   master beat with the new pose (x, y in 2^-24 m, saturating; heading as
//   a binary angle), the yaw quaternion z/w terms in Q1.15, the mean wheel
//   speed and the yaw rate in mrad/s.
//   After a beat is accepted, the multiplier steps (heading, rate and the
//   divide by 10^9 as a reciprocal multiply) run under the first CORDIC
//   pass, then three position steps and a second CORDIC pass for the
//   half-angle quaternion. One beat is in flight at a time: the next input
//   beat is taken only once the last one has left the final step.
//   A finished result sits in the output register; the next input beat is
//   taken while it waits. If the receiver stalls, the next result holds in
//   the final step until the register frees up, and no beat is dropped.
//   Reset clears the pose to zero, sets inverse_wheelbase to 1.0 (Q8.16)
//   and leaves both streams idle. Write the config only while idle.
module differential_drive_odometry_top import odo_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [23:0]  cfg_wr_data,    // inverse_wheelbase, Q8.16
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // left_velocity[15:0], right_velocity[31:16], elapsed_time[47:32]
    input  logic [47:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x[47:0], pos_y[95:48], heading[127:96], quat_z[143:128],
    // quat_w[159:144], linear_velocity[175:160], angular_rate[207:176]
    output logic [207:0] m_axis_tdata
);

    ctrl_cmd_t          cmd;
    dp_stat_t           stat;
    logic signed [47:0] pos_x, pos_y;
    logic [31:0]        heading;
    logic signed [15:0] quat_z, quat_w, linear_velocity;
    logic signed [31:0] angular_rate;

    // Sequence one beat at a time through the shared datapath
    odo_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold pose state and compute the update
    odo_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .left_velocity   (s_axis_tdata[15:0]),
        .right_velocity  (s_axis_tdata[31:16]),
        .elapsed_time    (s_axis_tdata[47:32]),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .heading         (heading),
        .quat_z          (quat_z),
        .quat_w          (quat_w),
        .linear_velocity (linear_velocity),
        .angular_rate    (angular_rate)
    );

    // Pack the result beat, first field lowest
    assign m_axis_tdata = {angular_rate, linear_velocity, quat_w, quat_z,
                           heading, pos_y, pos_x};

endmodule

// ----- bench/odometry_checker.sv -----
`timescale 1ns / 100ps
// Pose predictor and result checker for differential_drive_odometry_top.
// Watches the config port and both stream channels; no package dependency.
module odometry_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [23:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [207:0] m_axis_tdata,
    output int           fail_count,
    output int           pending
);

    localparam int          ROT_STEPS = 16;
    localparam longint      ROT_GAIN  = 64'sd652032874;
    localparam longint      YAW_SCALE = 64'd2935890503;
    localparam longint      POS_TOP   = 64'sd140737488355327;
    localparam longint      POS_BOT   = -64'sd140737488355328;

    typedef struct packed {
        logic [31:0] rate;
        logic [15:0] lin;
        logic [15:0] qw;
        logic [15:0] qz;
        logic [31:0] hd;
        logic [47:0] py;
        logic [47:0] px;
    } pose_beat_t;

    logic [31:0] arctan [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    longint      pos_x, pos_y;
    logic [31:0] yaw;
    logic [23:0] inv_track;
    pose_beat_t  pose_q[$];

    task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
        logic   flip;
        longint x, y, z, nx;
        flip = ang[31] ^ ang[30];
        if (flip)
            ang[31] = ~ang[31];
        x = ROT_GAIN;
        y = 0;
        z = longint'($signed(ang));
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(arctan[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(arctan[i]);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint clamp_pos(input longint v);
        if (v > POS_TOP)
            return POS_TOP;
        if (v < POS_BOT)
            return POS_BOT;
        return v;
    endfunction

    function automatic logic [15:0] round_q15(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    // Advance the pose by one update and return the beat it must produce.
    task automatic advance_pose(input logic [47:0] item, output pose_beat_t b);
        longint          vl, vr, sum, diff, travel, c, s, rate;
        longint unsigned dt, smag, dmag, r, lo, mid;
        logic [31:0]     inc, half;
        vl   = longint'($signed(item[15:0]));
        vr   = longint'($signed(item[31:16]));
        dt   = item[47:32];
        sum  = vl + vr;
        diff = vr - vl;
        smag = (sum < 0) ? -sum : sum;
        dmag = (diff < 0) ? -diff : diff;
        travel = ((smag * dt) << 23) / 64'd1000000000;
        if (sum < 0)
            travel = -travel;
        rotate(yaw, c, s);
        pos_x = clamp_pos(pos_x + ((travel * c) >>> 30));
        pos_y = clamp_pos(pos_y + ((travel * s) >>> 30));
        r   = dmag * dt * longint'(inv_track);
        lo  = (r & 64'hFFFF_FFFF) * YAW_SCALE;
        mid = (r >> 32) * YAW_SCALE + (lo >> 32);
        inc = mid[47:16];
        if (diff < 0)
            inc = -inc;
        yaw  = yaw + inc;
        rate = (dmag * longint'(inv_track)) >> 16;
        if (diff < 0)
            rate = -rate;
        half = {yaw[31], yaw[31:1]};
        rotate(half, c, s);
        b.px   = pos_x[47:0];
        b.py   = pos_y[47:0];
        b.hd   = yaw;
        b.qz   = round_q15(s);
        b.qw   = round_q15(c);
        b.lin  = sum[16:1];
        b.rate = rate[31:0];
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pose_beat_t b, g;
        if (!rst_n)
        begin
            pos_x      = 0;
            pos_y      = 0;
            yaw        = 0;
            inv_track  = 24'd65536;
            fail_count = 0;
            pose_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                g = m_axis_tdata;
                if (pose_q.size() == 0)
                    report("unexpected beat", 0, 0);
                else
                begin
                    b = pose_q.pop_front();
                    if (g.px != b.px)     report("pos_x", g.px, b.px);
                    if (g.py != b.py)     report("pos_y", g.py, b.py);
                    if (g.hd != b.hd)     report("heading", g.hd, b.hd);
                    if (g.qz != b.qz)     report("quat_z", g.qz, b.qz);
                    if (g.qw != b.qw)     report("quat_w", g.qw, b.qw);
                    if (g.lin != b.lin)   report("linear_velocity", g.lin, b.lin);
                    if (g.rate != b.rate) report("angular_rate", g.rate, b.rate);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_pose(s_axis_tdata, b);
                pose_q.push_back(b);
            end
            if (cfg_wr_en)
                inv_track = cfg_wr_data;
        end
        pending = pose_q.size();
    end

endmodule

// ----- bench/differential_drive_odometry_top_tb.sv -----
`timescale 1ns / 100ps
// Stimulus and verdict for differential_drive_odometry_top.
// Depends on the block's RTL and on odometry_checker for prediction.
module differential_drive_odometry_top_tb;

    localparam int RANDOM_ITEMS = 830;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 80;     // extra settle time once nothing is pending

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [23:0]  cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [207:0] m_axis_tdata;

    int  fail_count;
    int  pending;
    int  cycles;
    bit  gaps_on;        // random idling on both sides
    bit  hold_req;       // ask the receiver for one long hold-off

    differential_drive_odometry_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    odometry_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hung handshake.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("FAIL differential_drive_odometry_top");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request so the
    // block fills and back-pressures its input.
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (gaps_on && $urandom_range(3) == 0)
            begin
                n = $urandom_range(16, 1);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                n = $urandom_range(24, 1);
                m_axis_tready <= 1'b1;
                repeat (n) @(posedge clk);
            end
        end
    end

    // Offer one beat and hold it until accepted; drop valid only when a gap
    // follows, so back-to-back beats keep tvalid high.
    task automatic send_update(input logic [15:0] vl, input logic [15:0] vr,
                               input logic [15:0] dt);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dt, vr, vl};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (gaps_on && $urandom_range(2) == 0)
        begin
            gap = $urandom_range(16, 1);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Write inverse track only with the block drained and quiet.
    task automatic set_track(input logic [23:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random speed: full range half the time, otherwise an extreme or a small value.
    function automatic logic [15:0] pick_speed();
        case ($urandom_range(5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($signed($urandom_range(400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_dt();
        case ($urandom_range(5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [23:0] tracks [5];
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        gaps_on       = 1'b1;
        hold_req      = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, zero time, straight, spin, reverse.
        set_track(24'd65536);
        send_update(16'd0, 16'd0, 16'd0);
        send_update(16'h7FFF, 16'h7FFF, 16'd0);         // zero time, speeds still out
        send_update(16'h7FFF, 16'h7FFF, 16'hFFFF);      // fastest forward
        send_update(16'h8000, 16'h8000, 16'hFFFF);      // fastest reverse
        send_update(16'h8000, 16'h7FFF, 16'hFFFF);      // hardest left spin
        send_update(16'h7FFF, 16'h8000, 16'hFFFF);      // hardest right spin
        send_update(16'hFFFF, 16'h0000, 16'd1);         // odd sum, floor of mean
        send_update(16'd500, 16'd700, 16'd10000);
        set_track(24'hFFFFFF);                          // wrap the heading quickly
        for (int i = 0; i < 8; i++)
            send_update(16'h8000, 16'h7FFF, 16'hFFFF);
        send_update(16'd1000, 16'd1000, 16'd50000);
        set_track(24'd0);                               // heading frozen, rate zero
        send_update(16'h8000, 16'h7FFF, 16'hFFFF);
        send_update(16'd300, 16'd100, 16'd20000);
        set_track(24'd1);
        send_update(16'h8000, 16'h7FFF, 16'hFFFF);

        // Random: several track settings, the long hold-off early on, and a
        // stretch with no idling at the end.
        tracks = '{24'd65536, 24'd1, 24'hFFFFFF, 24'd0, 24'h000000};
        tracks[4] = 24'($urandom);
        for (int p = 0; p < 5; p++)
        begin
            set_track(tracks[p]);
            if (p == 0)
                hold_req = 1'b1;
            if (p == 4)
                gaps_on = 1'b0;
            for (int i = 0; i < RANDOM_ITEMS / 5; i++)
                send_update(pick_speed(), pick_speed(), pick_dt());
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS differential_drive_odometry_top");
        else
            $display("FAIL differential_drive_odometry_top");
        $finish;
    end

endmodule
